### rtl/mwv_pkg.sv
`timescale 1ns / 1ps
// mwv_pkg: shared types and constants of the multi-window VWAP block.
// Used by mwv_front, mwv_div, mwv_back, multi_window_vwap and the testbench.
package mwv_pkg;

    localparam int unsigned WIN_SLOTS = 4;

    localparam logic [2:0] CFG_WINDOW_COUNT = 3'd0;
    localparam logic [2:0] CFG_WINDOW_A     = 3'd1;
    localparam logic [2:0] CFG_WINDOW_B     = 3'd2;
    localparam logic [2:0] CFG_WINDOW_C     = 3'd3;
    localparam logic [2:0] CFG_WINDOW_D     = 3'd4;

    localparam logic [47:0] AVG_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [31:0]               trade_time;
        logic [31:0]               trade_price;
        logic [31:0]               trade_quantity;
        logic [2:0]                win_n;
        logic [WIN_SLOTS-1:0][31:0] win_len;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_RD,
        ST_CHK,
        ST_ACC,
        ST_DIV,
        ST_DIVW,
        ST_OUT
    } t_back_state;

endpackage

### rtl/mwv_ram.sv
`timescale 1ns / 1ps
// mwv_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module mwv_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/mwv_front.sv
`timescale 1ns / 1ps
// mwv_front: configuration registers, window ranking and the job queue.
// Depends on mwv_pkg.
module mwv_front import mwv_pkg::*; #(
    parameter int MAX_WINDOWS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_trade_time,
    input  logic [31:0] i_trade_price,
    input  logic [31:0] i_trade_quantity,
    output logic        o_job_valid,
    output t_job        o_job,
    input  logic        i_job_pop
);
    logic [2:0]                 r_win_count;
    logic [WIN_SLOTS-1:0][31:0] r_win;
    t_job                       r_q [2];
    logic                       r_head;
    logic [1:0]                 r_cnt;

    logic [2:0]                 n_active;
    logic [WIN_SLOTS-1:0][31:0] sorted;
    logic [WIN_SLOTS-1:0][1:0]  rank;
    t_job                       new_job;
    logic                       push;
    logic                       pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_count <= 3'd1;
            r_win[0]    <= 32'd60;
            r_win[1]    <= 32'd300;
            r_win[2]    <= 32'd900;
            r_win[3]    <= 32'd3600;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WINDOW_COUNT: r_win_count <= i_cfg_data[2:0];
                CFG_WINDOW_A:     r_win[0]    <= i_cfg_data;
                CFG_WINDOW_B:     r_win[1]    <= i_cfg_data;
                CFG_WINDOW_C:     r_win[2]    <= i_cfg_data;
                CFG_WINDOW_D:     r_win[3]    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_win_count == 3'd0) begin
            n_active = 3'd1;
        end else if (r_win_count > 3'(MAX_WINDOWS)) begin
            n_active = 3'(MAX_WINDOWS);
        end else begin
            n_active = r_win_count;
        end
    end

    // stable ranking: ties keep register order
    always_comb begin
        for (int i = 0; i < WIN_SLOTS; i++) begin
            rank[i] = 2'd0;
            for (int j = 0; j < WIN_SLOTS; j++) begin
                if (j != i && 3'(j) < n_active &&
                    ((r_win[j] < r_win[i]) || (r_win[j] == r_win[i] && j < i))) begin
                    rank[i] = rank[i] + 2'd1;
                end
            end
        end
        for (int r = 0; r < WIN_SLOTS; r++) begin
            sorted[r] = 32'd0;
            for (int i = 0; i < WIN_SLOTS; i++) begin
                if (3'(i) < n_active && rank[i] == 2'(r)) begin
                    sorted[r] = r_win[i];
                end
            end
        end
    end

    always_comb begin
        new_job.trade_time     = i_trade_time;
        new_job.trade_price    = i_trade_price;
        new_job.trade_quantity = i_trade_quantity;
        new_job.win_n          = n_active;
        new_job.win_len        = sorted;
    end

    assign o_in_stall  = (r_cnt == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign o_job_valid = (r_cnt != 2'd0);
    assign pop         = i_job_pop && o_job_valid;
    assign o_job       = r_q[r_head];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (pop) begin
                r_head <= ~r_head;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_head ^ (r_cnt != 2'd0)] <= new_job;
        end
    end
endmodule

### rtl/mwv_div.sv
`timescale 1ns / 1ps
// mwv_div: restoring divider, one quotient bit per cycle, 32.16 result clamped to 48 bits.
// Depends on mwv_pkg.
module mwv_div import mwv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_money,
    input  logic [63:0] i_qty,
    output logic        o_done,
    output logic [47:0] o_avg
);
    logic [79:0] r_dvd;
    logic [64:0] r_rem;
    logic [63:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_done;

    logic [64:0] rem_sh;
    logic        ge;

    assign rem_sh = {r_rem[63:0], r_dvd[79]};
    assign ge     = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 7'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= 7'd80;
            end else if (r_cnt != 7'd0) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {i_money, 16'd0};
            r_rem <= 65'd0;
            r_den <= i_qty;
        end else if (r_cnt != 7'd0) begin
            r_rem <= ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_dvd <= {r_dvd[78:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_avg  = (r_dvd[79:48] != 32'd0) ? AVG_MAX : r_dvd[47:0];
endmodule

### rtl/mwv_back.sv
`timescale 1ns / 1ps
// mwv_back: history ring, backward walk with saturating sums, per-window results.
// Depends on mwv_pkg, mwv_ram and mwv_div.
module mwv_back import mwv_pkg::*; #(
    parameter int HISTORY_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    input  t_job        i_job,
    output logic        o_job_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_window_index,
    output logic [47:0] o_average_price,
    output logic [10:0] o_trade_count,
    output logic        o_zero_volume,
    output logic        o_sum_saturated,
    output logic        o_last_window
);
    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);

    t_back_state r_state, n_state;
    t_job        r_job;
    logic [AW-1:0] r_wp, r_rptr;
    logic [CW-1:0] r_fill, r_count;
    logic [1:0]    r_win;
    logic [63:0]   r_money, r_qty, r_prod;
    logic [31:0]   r_q;
    logic          r_sat;
    logic [1:0]    r_o_index;
    logic [47:0]   r_o_avg;
    logic [10:0]   r_o_count;
    logic          r_o_zero, r_o_sat, r_o_last;

    logic [95:0] rdata;
    logic [31:0] rd_time, rd_price, rd_qty, age;
    logic        too_old, more, is_last, ram_we, div_start, div_done;
    logic [47:0] div_avg;
    logic [64:0] money_sum, qty_sum;

    mwv_ram #(.WIDTH(96), .DEPTH(HISTORY_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata ({r_job.trade_time, r_job.trade_price, r_job.trade_quantity}),
        .i_raddr (r_rptr),
        .o_rdata (rdata)
    );

    mwv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_money (r_money),
        .i_qty   (r_qty),
        .o_done  (div_done),
        .o_avg   (div_avg)
    );

    assign rd_time   = rdata[95:64];
    assign rd_price  = rdata[63:32];
    assign rd_qty    = rdata[31:0];
    assign age       = (rd_time > r_job.trade_time) ? 32'd0 : (r_job.trade_time - rd_time);
    assign too_old   = (age > r_job.win_len[r_win]);
    assign more      = (r_count < r_fill);
    assign is_last   = (({1'b0, r_win} + 3'd1) == r_job.win_n);
    assign money_sum = {1'b0, r_money} + {1'b0, r_prod};
    assign qty_sum   = {1'b0, r_qty} + {33'd0, r_q};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_job_valid) n_state = ST_START;
            ST_START: n_state = ST_RD;
            ST_RD:    n_state = more ? ST_CHK : ST_DIV;
            ST_CHK:   n_state = too_old ? ST_DIV : ST_ACC;
            ST_ACC:   n_state = ST_RD;
            ST_DIV:   n_state = (r_qty == 64'd0) ? ST_OUT : ST_DIVW;
            ST_DIVW:  if (div_done) n_state = ST_OUT;
            ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = r_o_last ? ST_IDLE : ST_RD;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop   = (r_state == ST_IDLE) && i_job_valid;
        ram_we      = (r_state == ST_START);
        div_start   = (r_state == ST_DIV) && (r_qty != 64'd0);
        o_out_valid = (r_state == ST_OUT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wp    <= '0;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_START) begin
                r_wp <= (r_wp == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                if (r_fill != CW'(HISTORY_DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_job <= i_job;
            end
            ST_START: begin
                r_rptr  <= r_wp;
                r_count <= '0;
                r_win   <= 2'd0;
                r_money <= 64'd0;
                r_qty   <= 64'd0;
                r_sat   <= 1'b0;
            end
            ST_CHK: begin
                r_prod <= rd_price * rd_qty;
                r_q    <= rd_qty;
            end
            ST_ACC: begin
                r_money <= money_sum[64] ? '1 : money_sum[63:0];
                r_qty   <= qty_sum[64] ? '1 : qty_sum[63:0];
                r_sat   <= r_sat | money_sum[64] | qty_sum[64];
                r_count <= r_count + 1'b1;
                r_rptr  <= (r_rptr == '0) ? AW'(HISTORY_DEPTH - 1) : r_rptr - 1'b1;
            end
            ST_DIV: begin
                r_o_index <= r_win;
                r_o_count <= 11'(r_count);
                r_o_zero  <= (r_qty == 64'd0);
                r_o_sat   <= r_sat;
                r_o_last  <= is_last;
                r_o_avg   <= 48'd0;
            end
            ST_DIVW: begin
                if (div_done) begin
                    r_o_avg <= div_avg;
                end
            end
            ST_OUT: begin
                if (!i_out_stall && !r_o_last) begin
                    r_win <= r_win + 2'd1;
                end
            end
            default: ;
        endcase
    end

    assign o_window_index  = r_o_index;
    assign o_average_price = r_o_avg;
    assign o_trade_count   = r_o_count;
    assign o_zero_volume   = r_o_zero;
    assign o_sum_saturated = r_o_sat;
    assign o_last_window   = r_o_last;
endmodule

### rtl/multi_window_vwap.sv
`timescale 1ns / 1ps
// multi_window_vwap: per trade, one VWAP result per active window (up to 4).
// steps: setup (IDLE pops the job, START writes it to the ring); per history entry walked
// (at most depth per trade) read, check, accumulate; per window the walk ends, then an
// 80-bit divide, result (or result alone on zero volume); one trade at a time, stalls hold it.
// reset: synchronous; clears queue, ring pointer, fill count, config to defaults.
// History RAM is not cleared; only entries written since reset are walked.
module multi_window_vwap import mwv_pkg::*; #(
    parameter int HISTORY_DEPTH = 1024,
    parameter int MAX_WINDOWS   = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_trade_time,
    input  logic [31:0] i_trade_price,
    input  logic [31:0] i_trade_quantity,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_window_index,
    output logic [47:0] o_average_price,
    output logic [10:0] o_trade_count,
    output logic        o_zero_volume,
    output logic        o_sum_saturated,
    output logic        o_last_window
);
    logic job_valid, job_pop;
    t_job job;

    mwv_front #(.MAX_WINDOWS(MAX_WINDOWS)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_trade_time     (i_trade_time),
        .i_trade_price    (i_trade_price),
        .i_trade_quantity (i_trade_quantity),
        .o_job_valid      (job_valid),
        .o_job            (job),
        .i_job_pop        (job_pop)
    );

    mwv_back #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (job_valid),
        .i_job           (job),
        .o_job_pop       (job_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_window_index  (o_window_index),
        .o_average_price (o_average_price),
        .o_trade_count   (o_trade_count),
        .o_zero_volume   (o_zero_volume),
        .o_sum_saturated (o_sum_saturated),
        .o_last_window   (o_last_window)
    );
endmodule

### rtl/mwv_checker.sv
`timescale 1ns / 1ps
// mwv_checker: port-level assertions for multi_window_vwap, with its bind.
// Depends on multi_window_vwap ports only.
module mwv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [2:0]  i_cfg_index,
    input logic [31:0] i_cfg_data,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [31:0] i_trade_time,
    input logic [31:0] i_trade_price,
    input logic [31:0] i_trade_quantity,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_window_index,
    input logic [47:0] o_average_price,
    input logic [10:0] o_trade_count,
    input logic        o_zero_volume,
    input logic        o_sum_saturated,
    input logic        o_last_window
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_average_price) && $stable(o_trade_count)
            && $stable(o_window_index) && $stable(o_last_window))
        else $error("stalled result changed");

    a_zero_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_volume |-> o_average_price == 48'd0)
        else $error("zero volume with nonzero average");

    a_next_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_window
            |=> o_out_valid == 1'b0 || o_window_index == $past(o_window_index) + 2'd1)
        else $error("window index did not advance");
endmodule

bind multi_window_vwap mwv_checker u_mwv_checker (.*);

### verif/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench of multi_window_vwap, with a scoreboard that recomputes
// each trade's windowed averages. Depends on rtl/mwv_pkg.sv and rtl/multi_window_vwap.sv.
module tb_top;
    import mwv_pkg::*;

    typedef struct {
        logic [1:0]  window_index;
        logic [47:0] average_price;
        logic [10:0] trade_count;
        logic        zero_volume;
        logic        sum_saturated;
        logic        last_window;
    } vwap_result_t;

    class vwap_scoreboard;
        logic [31:0] hist_time [1024];
        logic [31:0] hist_price [1024];
        logic [31:0] hist_qty [1024];
        int unsigned wr_pos;
        int unsigned fill;
        logic [2:0]  win_count;
        logic [31:0] win_len [4];
        vwap_result_t pending_q [$];
        int errors;

        function new();
            wr_pos = 0;
            fill = 0;
            win_count = 3'd1;
            win_len[0] = 60;
            win_len[1] = 300;
            win_len[2] = 900;
            win_len[3] = 3600;
            errors = 0;
        endfunction

        function void note_config(logic [2:0] index, logic [31:0] data);
            if (index == CFG_WINDOW_COUNT) begin
                win_count = data[2:0];
            end else if (index <= CFG_WINDOW_D) begin
                win_len[index - CFG_WINDOW_A] = data;
            end
        endfunction

        function logic [47:0] fixed_average(longint unsigned money, longint unsigned qty);
            longint unsigned quo;
            logic [64:0] rem;
            logic [15:0] frac;
            quo = money / qty;
            rem = {1'b0, money % qty};
            frac = '0;
            if (quo > 64'hFFFF_FFFF) return AVG_MAX;
            for (int b = 0; b < 16; b++) begin
                rem = rem << 1;
                frac = frac << 1;
                if (rem >= {1'b0, qty}) begin
                    rem = rem - {1'b0, qty};
                    frac[0] = 1'b1;
                end
            end
            return {quo[31:0], frac};
        endfunction

        function void note_trade(logic [31:0] t, logic [31:0] p, logic [31:0] q);
            logic [31:0] ranked [4];
            logic [31:0] v, age;
            int unsigned n, j, cnt, newest, idx;
            longint unsigned money, qsum, prod, s;
            logic sat;
            vwap_result_t r;
            hist_time[wr_pos] = t;
            hist_price[wr_pos] = p;
            hist_qty[wr_pos] = q;
            newest = wr_pos;
            wr_pos = (wr_pos + 1) % 1024;
            if (fill < 1024) fill++;
            n = win_count;
            if (n < 1) n = 1;
            if (n > 4) n = 4;
            for (int i = 0; i < n; i++) begin
                v = win_len[i];
                j = i;
                while (j > 0 && ranked[j-1] > v) begin
                    ranked[j] = ranked[j-1];
                    j--;
                end
                ranked[j] = v;
            end
            cnt = 0;
            money = 0;
            qsum = 0;
            sat = 1'b0;
            for (int i = 0; i < n; i++) begin
                while (cnt < fill) begin
                    idx = (newest + 1024 - cnt) % 1024;
                    age = (hist_time[idx] > t) ? 32'd0 : t - hist_time[idx];
                    if (age > ranked[i]) break;
                    prod = longint'(hist_price[idx]) * longint'(hist_qty[idx]);
                    s = money + prod;
                    if (s < money) begin sat = 1'b1; s = '1; end
                    money = s;
                    s = qsum + hist_qty[idx];
                    if (s < qsum) begin sat = 1'b1; s = '1; end
                    qsum = s;
                    cnt++;
                end
                r.window_index = i[1:0];
                r.average_price = (qsum == 0) ? 48'd0 : fixed_average(money, qsum);
                r.trade_count = cnt[10:0];
                r.zero_volume = (qsum == 0);
                r.sum_saturated = sat;
                r.last_window = (i + 1 == n);
                pending_q.push_back(r);
            end
        endfunction

        function void check_result(vwap_result_t got);
            vwap_result_t e;
            if (pending_q.size() == 0) begin
                $error("unexpected result transfer, window_index %0d", got.window_index);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (got.window_index !== e.window_index) begin
                $error("window_index exp %0d got %0d", e.window_index, got.window_index);
                errors++;
            end
            if (got.average_price !== e.average_price) begin
                $error("average_price exp %h got %h", e.average_price, got.average_price);
                errors++;
            end
            if (got.trade_count !== e.trade_count) begin
                $error("trade_count exp %0d got %0d", e.trade_count, got.trade_count);
                errors++;
            end
            if (got.zero_volume !== e.zero_volume) begin
                $error("zero_volume exp %b got %b", e.zero_volume, got.zero_volume);
                errors++;
            end
            if (got.sum_saturated !== e.sum_saturated) begin
                $error("sum_saturated exp %b got %b", e.sum_saturated, got.sum_saturated);
                errors++;
            end
            if (got.last_window !== e.last_window) begin
                $error("last_window exp %b got %b", e.last_window, got.last_window);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [31:0] i_trade_time = '0;
    logic [31:0] i_trade_price = '0;
    logic [31:0] i_trade_quantity = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_window_index;
    logic [47:0] o_average_price;
    logic [10:0] o_trade_count;
    logic        o_zero_volume;
    logic        o_sum_saturated;
    logic        o_last_window;

    vwap_scoreboard sb;
    logic [31:0] clock_now = '0;
    bit quiet = 1'b0;
    int hold_ask = 0;
    int hold_seen = 0;
    int hold_left = 0;

    multi_window_vwap dut (.*);

    always #5 i_clk = ~i_clk;

    initial begin
        #100ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge i_clk) begin
        vwap_result_t got;
        if (i_rst_n && sb != null && o_out_valid && !i_out_stall) begin
            got.window_index = o_window_index;
            got.average_price = o_average_price;
            got.trade_count = o_trade_count;
            got.zero_volume = o_zero_volume;
            got.sum_saturated = o_sum_saturated;
            got.last_window = o_last_window;
            sb.check_result(got);
        end
        if (hold_ask != hold_seen) begin
            hold_seen <= hold_ask;
            hold_left <= 3000;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 25);
        end
    end

    task automatic write_reg(logic [2:0] index, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.note_config(index, data);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_trade(logic [31:0] t, logic [31:0] p, logic [31:0] q);
        if (!quiet && $urandom_range(0, 99) < 25) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_trade_time <= t;
        i_trade_price <= p;
        i_trade_quantity <= q;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_trade(t, p, q);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_window();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(0, 150);
        endcase
    endfunction

    task automatic random_trade();
        logic [31:0] p, q;
        if ($urandom_range(0, 19) == 0) clock_now = $urandom;
        else clock_now = clock_now + $urandom_range(0, 20);
        p = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 5000);
        case ($urandom_range(0, 9))
            0: q = 32'd0;
            1, 2: q = $urandom;
            default: q = $urandom_range(1, 1000);
        endcase
        send_trade(clock_now, p, q);
    endtask

    initial begin
        logic [2:0] counts [8] = '{3'd7, 3'd2, 3'd3, 3'd0, 3'd4, 3'd5, 3'd1, 3'd6};
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default config: zero volume, saturation, out-of-order time
        send_trade(32'd100, 32'd0, 32'd0);
        send_trade(32'd110, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_trade(32'd120, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_trade(32'd50, 32'd7, 32'd3);
        send_trade(32'hFFFF_FFFF, 32'd1, 32'd1);
        drain();

        // unsorted and equal lengths, extremes
        write_reg(CFG_WINDOW_COUNT, 32'd4);
        write_reg(CFG_WINDOW_A, 32'hFFFF_FFFF);
        write_reg(CFG_WINDOW_B, 32'd5);
        write_reg(CFG_WINDOW_C, 32'd0);
        write_reg(CFG_WINDOW_D, 32'd5);
        send_trade(32'hFFFF_FFFF, 32'd10, 32'd0);
        send_trade(32'h0000_0000, 32'd3, 32'd2);
        send_trade(32'd3, 32'd5, 32'd9);
        send_trade(32'd3, 32'd5, 32'd9);
        send_trade(32'd10, 32'hFFFF_FFFF, 32'd1);
        send_trade(32'd20, 32'd1, 32'hFFFF_FFFF);
        send_trade(32'd20, 32'hAAAA_AAAA, 32'h5555_5555);
        send_trade(32'd21, 32'h5555_5555, 32'hAAAA_AAAA);
        drain();

        clock_now = 32'd1000;
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_WINDOW_COUNT, {29'd0, counts[ph]});
            write_reg(CFG_WINDOW_A, pick_window());
            write_reg(CFG_WINDOW_B, pick_window());
            write_reg(CFG_WINDOW_C, pick_window());
            write_reg(CFG_WINDOW_D, pick_window());
            quiet = (ph == 2);
            for (int k = 0; k < 54; k++) begin
                if (ph == 4 && k == 5) hold_ask = hold_ask + 1;
                random_trade();
            end
            quiet = 1'b0;
            drain();
        end

        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

### files.f
rtl/mwv_pkg.sv
rtl/mwv_ram.sv
rtl/mwv_front.sv
rtl/mwv_div.sv
rtl/mwv_back.sv
rtl/multi_window_vwap.sv
rtl/mwv_checker.sv
verif/tb_top.sv
